>>> hw/rtl/sfrc8_pkg.sv
// ----------------------------------------------------------------------------
// sfrc8_pkg: shared types and constants for the serial frame receiver
// Holds field widths, header bytes, parse phase codes, event codes and the
// bytewise reflected CRC-8 update.
// ----------------------------------------------------------------------------
package sfrc8_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 2;
  localparam int unsigned PhaseW = 3;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [EventW-1:0] event_t;
  typedef logic [PhaseW-1:0] phase_t;

  localparam byte_t HdrFirst  = 8'hAA;
  localparam byte_t HdrSecond = 8'h55;
  localparam byte_t CrcPoly   = 8'h8C;
  localparam byte_t CountStep = 8'h01;

  // Parse phases
  localparam phase_t PH_HEAD0   = 3'd0;
  localparam phase_t PH_HEAD1   = 3'd1;
  localparam phase_t PH_FUNC    = 3'd2;
  localparam phase_t PH_LEN     = 3'd3;
  localparam phase_t PH_PAYLOAD = 3'd4;
  localparam phase_t PH_CRC     = 3'd5;

  // Event codes
  localparam event_t EV_NONE = 2'd0;
  localparam event_t EV_GOOD = 2'd1;
  localparam event_t EV_BAD  = 2'd2;

  typedef struct packed {
    event_t event_res;
    logic   is_payload;
    byte_t  payload_pos;
    byte_t  func_code;
    byte_t  length_seen;
    byte_t  crc_calc;
    byte_t  crc_recv;
  } res_t;

  // Reflected CRC-8, one byte: eight shift/xor steps on an 8-bit value.
  function automatic byte_t crc8_feed(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/sfrc8_if.sv
// ----------------------------------------------------------------------------
// sfrc8 channel interfaces
// Valid/ready channels for received bytes and for per-byte results.
// ----------------------------------------------------------------------------
interface sfrc8_in_if;
  import sfrc8_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrc8_out_if;
  import sfrc8_pkg::*;

  logic   valid;
  logic   ready;
  event_t event_res;
  logic   is_payload;
  byte_t  payload_pos;
  byte_t  func_code;
  byte_t  length_seen;
  byte_t  crc_calc;
  byte_t  crc_recv;

  modport source (output valid, output event_res, output is_payload, output payload_pos,
                  output func_code, output length_seen, output crc_calc, output crc_recv,
                  input ready);
  modport sink   (input valid, input event_res, input is_payload, input payload_pos,
                  input func_code, input length_seen, input crc_calc, input crc_recv,
                  output ready);
endinterface

>>> hw/rtl/serial_frame_receiver_crc8.sv
// A result item is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; parser, counters, one bytewise
//   CRC-8 update sit between the accepted byte and the result register.
// A byte is taken whenever the result register is empty or being drained.
// Reset (rst_n low, synchronous) returns the parser to waiting for 0xAA,
//   clears counts, function, length and CRC, and empties the result register.
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc8: byte-serial frame parser with CRC-8 check
// Recognizes 0xAA 0x55 func len payload crc frames and reports one result
// item per received byte.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc8 (
  input logic        clk,
  input logic        rst_n,
  sfrc8_in_if.sink   in_ch,
  sfrc8_out_if.source out_ch
);
  import sfrc8_pkg::*;

  // Parser state
  phase_t phase_r,   phase_nxt;
  byte_t  count_r,   count_nxt;
  byte_t  length_r,  length_nxt;
  byte_t  func_r,    func_nxt;
  byte_t  crc_r,     crc_nxt;

  // Result register
  logic   out_valid_r, out_valid_nxt;
  res_t   res_r,       res_nxt;

  logic   in_acc;
  byte_t  b;
  byte_t  count_inc;
  byte_t  crc_upd;

  // Take a new byte while the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign count_inc   = count_r + CountStep;

  // One CRC update serves the function, length and payload phases; the
  // function byte starts from a zero CRC.
  assign crc_upd = crc8_feed((phase_r == PH_FUNC) ? '0 : crc_r, b);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    func_nxt   = func_r;
    crc_nxt    = crc_r;

    res_nxt             = '0;
    res_nxt.event_res   = EV_NONE;

    case (phase_r)
      PH_HEAD0: begin
        // Start of frame: clear what the last frame left.
        if (b == HdrFirst) begin
          func_nxt   = '0;
          length_nxt = '0;
          count_nxt  = '0;
          crc_nxt    = '0;
          phase_nxt  = PH_HEAD1;
        end
      end
      PH_HEAD1: begin
        // Drop back on anything but 0x55, a repeated 0xAA included.
        phase_nxt = (b == HdrSecond) ? PH_FUNC : PH_HEAD0;
      end
      PH_FUNC: begin
        func_nxt  = b;
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        length_nxt = b;
        count_nxt  = '0;
        crc_nxt    = crc_upd;
        // Empty payload: go straight to the CRC byte.
        phase_nxt  = (b == '0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_nxt.is_payload  = 1'b1;
        res_nxt.payload_pos = count_r;
        crc_nxt             = crc_upd;
        count_nxt           = count_inc;
        if (count_inc == length_r) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        res_nxt.crc_recv  = b;
        res_nxt.event_res = (b == crc_r) ? EV_GOOD : EV_BAD;
        phase_nxt         = PH_HEAD0;
      end
      default: begin
        // Unreachable codes: ignore the byte and resync.
        phase_nxt = PH_HEAD0;
      end
    endcase

    res_nxt.func_code   = func_nxt;
    res_nxt.length_seen = length_nxt;
    res_nxt.crc_calc    = crc_nxt;
  end

  // Hold the result until taken; load a new one on each accepted byte.
  assign out_valid_nxt = in_acc ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD0;
      count_r     <= '0;
      length_r    <= '0;
      func_r      <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        length_r <= length_nxt;
        func_r   <= func_nxt;
        crc_r    <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_res   = res_r.event_res;
  assign out_ch.is_payload  = res_r.is_payload;
  assign out_ch.payload_pos = res_r.payload_pos;
  assign out_ch.func_code   = res_r.func_code;
  assign out_ch.length_seen = res_r.length_seen;
  assign out_ch.crc_calc    = res_r.crc_calc;
  assign out_ch.crc_recv    = res_r.crc_recv;

  // In the payload phase the count always stays below the frame length.
  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> count_r < length_r)
    else $error("payload count reached frame length inside payload phase");

  // A CRC byte always yields a completed-frame event.
  a_crc_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_CRC |=>
      out_valid_r && (res_r.event_res == EV_GOOD || res_r.event_res == EV_BAD))
    else $error("CRC byte produced no frame event");

  // A payload result never carries a frame event.
  a_payload_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.is_payload |-> res_r.event_res == EV_NONE)
    else $error("payload item carries a frame event");

  // Second header byte either advances to the function code or resyncs.
  a_head1_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_HEAD1 |=> phase_r == PH_FUNC || phase_r == PH_HEAD0)
    else $error("bad transition out of second header phase");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule
